### hw/rtl/spt_pkg.sv
`timescale 1ns / 1ps

package spt_pkg;

    // Widths follow from the 16-bit number field and MAX_N = 65535.
    localparam int NUM_W     = 16;
    localparam int MAX_N     = 65535;
    localparam int BMP_DEPTH = MAX_N + 1;
    localparam int ADDR_W    = 16;
    // Walking multiple m may overshoot n by up to k, so it needs one extra bit.
    localparam int M_W       = NUM_W + 1;
    // k never exceeds 256, since 256 * 256 is above MAX_N.
    localparam int K_W       = 9;
    localparam int KK_W      = NUM_W + 1;
    localparam int STEP_W    = 4;

    typedef logic [STEP_W-1:0] step_t;

    // Microprogram step addresses.
    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_CLEAR = 4'd1;
    localparam step_t STEP_INIT  = 4'd2;
    localparam step_t STEP_KTEST = 4'd3;
    localparam step_t STEP_KCHK  = 4'd4;
    localparam step_t STEP_MARK  = 4'd5;
    localparam step_t STEP_KNEXT = 4'd6;
    localparam step_t STEP_READN = 4'd7;
    localparam step_t STEP_DONE  = 4'd8;

    typedef enum logic [1:0] {
        ADDR_M,
        ADDR_K,
        ADDR_N
    } addr_sel_t;

    typedef enum logic [2:0] {
        M_HOLD,
        M_ZERO,
        M_INC,
        M_TWO_K,
        M_ADD_K
    } m_op_t;

    typedef enum logic [1:0] {
        K_HOLD,
        K_INIT,
        K_INC
    } k_op_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_TAKE,
        COND_M_EQ_N,
        COND_N_LT2,
        COND_KK_GT_N,
        COND_MARKED,
        COND_M_GT_N,
        COND_OUT_FREE
    } cond_t;

    typedef enum logic {
        ELSE_NEXT,
        ELSE_STAY
    } else_t;

    // One control word of the microprogram.
    typedef struct packed {
        addr_sel_t addr_sel;
        logic      mem_we;
        logic      we_unless_cond;
        logic      mem_wdata;
        m_op_t     m_op;
        k_op_t     k_op;
        logic      out_load;
        cond_t     cond;
        step_t     target;
        else_t     else_op;
    } ucode_t;

    // Datapath controls after the sequencer has resolved the condition.
    typedef struct packed {
        addr_sel_t addr_sel;
        logic      mem_we;
        logic      mem_wdata;
        m_op_t     m_op;
        k_op_t     k_op;
        logic      n_load;
        logic      out_load;
    } dp_ctrl_t;

    // Flags the datapath returns for conditional jumps.
    typedef struct packed {
        logic m_eq_n;
        logic m_gt_n;
        logic n_lt2;
        logic kk_gt_n;
        logic marked;
        logic out_free;
    } dp_stat_t;

    function automatic ucode_t ucode(input step_t step);
        ucode_t uw;
        uw.addr_sel       = ADDR_M;
        uw.mem_we         = 1'b0;
        uw.we_unless_cond = 1'b0;
        uw.mem_wdata      = 1'b0;
        uw.m_op           = M_HOLD;
        uw.k_op           = K_HOLD;
        uw.out_load       = 1'b0;
        uw.cond           = COND_ALWAYS;
        uw.target         = STEP_IDLE;
        uw.else_op        = ELSE_STAY;
        case (step)
            STEP_IDLE:
            begin
                uw.m_op    = M_ZERO;
                uw.cond    = COND_IN_TAKE;
                uw.target  = STEP_CLEAR;
                uw.else_op = ELSE_STAY;
            end
            STEP_CLEAR:
            begin
                uw.addr_sel  = ADDR_M;
                uw.mem_we    = 1'b1;
                uw.mem_wdata = 1'b0;
                uw.m_op      = M_INC;
                uw.cond      = COND_M_EQ_N;
                uw.target    = STEP_INIT;
                uw.else_op   = ELSE_STAY;
            end
            STEP_INIT:
            begin
                uw.k_op    = K_INIT;
                uw.cond    = COND_N_LT2;
                uw.target  = STEP_DONE;
                uw.else_op = ELSE_NEXT;
            end
            STEP_KTEST:
            begin
                uw.addr_sel = ADDR_K;
                uw.cond     = COND_KK_GT_N;
                uw.target   = STEP_READN;
                uw.else_op  = ELSE_NEXT;
            end
            STEP_KCHK:
            begin
                uw.m_op    = M_TWO_K;
                uw.cond    = COND_MARKED;
                uw.target  = STEP_KNEXT;
                uw.else_op = ELSE_NEXT;
            end
            STEP_MARK:
            begin
                uw.addr_sel       = ADDR_M;
                uw.mem_we         = 1'b1;
                uw.we_unless_cond = 1'b1;
                uw.mem_wdata      = 1'b1;
                uw.m_op           = M_ADD_K;
                uw.cond           = COND_M_GT_N;
                uw.target         = STEP_KNEXT;
                uw.else_op        = ELSE_STAY;
            end
            STEP_KNEXT:
            begin
                uw.k_op   = K_INC;
                uw.cond   = COND_ALWAYS;
                uw.target = STEP_KTEST;
            end
            STEP_READN:
            begin
                uw.addr_sel = ADDR_N;
                uw.cond     = COND_NEVER;
                uw.else_op  = ELSE_NEXT;
            end
            STEP_DONE:
            begin
                uw.addr_sel = ADDR_N;
                uw.out_load = 1'b1;
                uw.cond     = COND_OUT_FREE;
                uw.target   = STEP_IDLE;
                uw.else_op  = ELSE_STAY;
            end
            default:
            begin
                uw.cond   = COND_ALWAYS;
                uw.target = STEP_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

### hw/rtl/spt_bitmap.sv
`timescale 1ns / 1ps

// Composite bitmap: one write or read address per cycle, registered read data.
module spt_bitmap (
    input  logic                       clk,
    input  logic [spt_pkg::ADDR_W-1:0] addr,
    input  logic                       we,
    input  logic                       wdata,
    output logic                       rdata
);

    logic mem [0:spt_pkg::BMP_DEPTH-1];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/spt_datapath.sv
`timescale 1ns / 1ps

// Sieve registers, bitmap and the output register.
module spt_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  spt_pkg::dp_ctrl_t         ctrl,
    input  logic [spt_pkg::NUM_W-1:0] number,
    input  logic                      out_stall,
    output spt_pkg::dp_stat_t         stat,
    output logic                      out_valid,
    output logic                      is_prime
);

    logic [spt_pkg::NUM_W-1:0]  n_reg;
    logic [spt_pkg::M_W-1:0]    m_reg,  m_next;
    logic [spt_pkg::K_W-1:0]    k_reg,  k_next;
    logic [spt_pkg::KK_W-1:0]   kk_reg, kk_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       is_prime_reg;
    logic [spt_pkg::ADDR_W-1:0] mem_addr;
    logic                       marked;
    logic [spt_pkg::M_W-1:0]    n_wide;

    assign n_wide = spt_pkg::M_W'(n_reg);

    always_comb
    begin
        case (ctrl.addr_sel)
            spt_pkg::ADDR_M: mem_addr = m_reg[spt_pkg::ADDR_W-1:0];
            spt_pkg::ADDR_K: mem_addr = spt_pkg::ADDR_W'(k_reg);
            spt_pkg::ADDR_N: mem_addr = n_reg;
            default:         mem_addr = n_reg;
        endcase
    end

    spt_bitmap u_bitmap (
        .clk   (clk),
        .addr  (mem_addr),
        .we    (ctrl.mem_we),
        .wdata (ctrl.mem_wdata),
        .rdata (marked)
    );

    always_comb
    begin
        case (ctrl.m_op)
            spt_pkg::M_HOLD:  m_next = m_reg;
            spt_pkg::M_ZERO:  m_next = '0;
            spt_pkg::M_INC:   m_next = m_reg + spt_pkg::M_W'(1);
            spt_pkg::M_TWO_K: m_next = spt_pkg::M_W'({k_reg, 1'b0});
            spt_pkg::M_ADD_K: m_next = m_reg + spt_pkg::M_W'(k_reg);
            default:          m_next = m_reg;
        endcase
    end

    // kk tracks k*k: (k+1)^2 = k^2 + 2k + 1.
    always_comb
    begin
        case (ctrl.k_op)
            spt_pkg::K_HOLD:
            begin
                k_next  = k_reg;
                kk_next = kk_reg;
            end
            spt_pkg::K_INIT:
            begin
                k_next  = spt_pkg::K_W'(2);
                kk_next = spt_pkg::KK_W'(4);
            end
            spt_pkg::K_INC:
            begin
                k_next  = k_reg + spt_pkg::K_W'(1);
                kk_next = kk_reg + spt_pkg::KK_W'({k_reg, 1'b0}) + spt_pkg::KK_W'(1);
            end
            default:
            begin
                k_next  = k_reg;
                kk_next = kk_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.n_load)
        begin
            n_reg <= number;
        end
        m_reg  <= m_next;
        k_reg  <= k_next;
        kk_reg <= kk_next;
        if (ctrl.out_load)
        begin
            is_prime_reg <= !stat.n_lt2 && !marked;
        end
    end

    assign stat.m_eq_n   = (m_reg == n_wide);
    assign stat.m_gt_n   = (m_reg > n_wide);
    assign stat.n_lt2    = (n_reg < spt_pkg::NUM_W'(2));
    assign stat.kk_gt_n  = (kk_reg > spt_pkg::KK_W'(n_reg));
    assign stat.marked   = marked;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule

### hw/rtl/spt_sequencer.sv
`timescale 1ns / 1ps

// Step counter over the control store, with conditional jumps.
module spt_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  spt_pkg::dp_stat_t  stat,
    output logic               in_stall,
    output spt_pkg::dp_ctrl_t  ctrl
);

    spt_pkg::step_t  step_reg, step_next;
    spt_pkg::ucode_t uw;
    logic            in_take;
    logic            cond_true;

    assign uw       = spt_pkg::ucode(step_reg);
    assign in_stall = (step_reg != spt_pkg::STEP_IDLE);
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        case (uw.cond)
            spt_pkg::COND_NEVER:    cond_true = 1'b0;
            spt_pkg::COND_ALWAYS:   cond_true = 1'b1;
            spt_pkg::COND_IN_TAKE:  cond_true = in_take;
            spt_pkg::COND_M_EQ_N:   cond_true = stat.m_eq_n;
            spt_pkg::COND_N_LT2:    cond_true = stat.n_lt2;
            spt_pkg::COND_KK_GT_N:  cond_true = stat.kk_gt_n;
            spt_pkg::COND_MARKED:   cond_true = stat.marked;
            spt_pkg::COND_M_GT_N:   cond_true = stat.m_gt_n;
            spt_pkg::COND_OUT_FREE: cond_true = stat.out_free;
            default:                cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_true)
        begin
            step_next = uw.target;
        end
        else if (uw.else_op == spt_pkg::ELSE_NEXT)
        begin
            step_next = step_reg + spt_pkg::STEP_W'(1);
        end
        else
        begin
            step_next = step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= spt_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        ctrl.addr_sel  = uw.addr_sel;
        ctrl.mem_we    = uw.mem_we && !(uw.we_unless_cond && cond_true);
        ctrl.mem_wdata = uw.mem_wdata;
        ctrl.m_op      = uw.m_op;
        ctrl.k_op      = uw.k_op;
        ctrl.n_load    = in_take;
        ctrl.out_load  = uw.out_load && cond_true;
    end

endmodule

### hw/rtl/sieve_primality_test.sv
`timescale 1ns / 1ps
// Every number first clears entries 0..n; each k from 2 while k*k <= n that is already marked is
// skipped, and every other k walks its multiples up to n. Numbers below two skip the sieve.
// The block takes no new number until the previous result is loaded into the output register; a
// result that waits in the output register holds the sequencer. Reset clears the step counter and
// the output valid flag; the bitmap is not reset because every run clears entries 0..n before
// reading them.

// The block is a small microcoded engine. The sequencer steps through a
// control store of nine words; each word selects the bitmap address, the
// update of the walking registers and a jump condition. The datapath holds
// the number under test, the sieving prime k together with k*k (kept by
// adding 2k+1 on each increment, so no multiplier is needed), the walking
// multiple m, the single-port bitmap and the output register.
//
// Program outline: wait for a transfer on the input, clear entries 0..n,
// then for each k with k*k <= n read k's mark and, if it is clear, mark
// 2k, 3k, ... up to n. Finally read n's mark and load the answer once the
// output register is free. Numbers below two skip the sieve and report
// not prime.
module sieve_primality_test (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [spt_pkg::NUM_W-1:0] number,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      is_prime
);

    spt_pkg::dp_ctrl_t ctrl;
    spt_pkg::dp_stat_t stat;

    spt_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    spt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .number    (number),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .is_prime  (is_prime)
    );

endmodule
